### rtl/brms_pkg.sv
// ----------------------------------------------------------------------------
// brms_pkg: shared types and constants of the block RMS level meter
// Field widths, per-channel accumulator sizes and the handshake structs
// between the sequencer and the divide/root unit.
// ----------------------------------------------------------------------------
package brms_pkg;

    // channel count and block length limit
    localparam int CHANNELS  = 8;
    localparam int MAX_BLOCK = 4096;

    // field and state widths
    localparam int CH_W    = 3;
    localparam int SMP_W   = 24;
    localparam int LVL_W   = 24;
    localparam int SUM_W   = 59;
    localparam int CNT_W   = 13;
    localparam int ALPHA_W = 17;
    localparam int PROD_W  = 2 * SMP_W;
    localparam int MIX_W   = 40;

    // block mean of squares never exceeds 2^46, so 47 quotient bits suffice
    localparam int MEAN_W     = 47;
    localparam int DIV_HI_W   = SUM_W - MEAN_W;
    localparam int SQRT_STEPS = (MEAN_W + 1) / 2;
    localparam int STEP_W     = 6;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

    // request to the divide/root unit
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_ds_req;

    // response from the divide/root unit
    typedef struct packed {
        logic             done;
        logic [LVL_W-1:0] root;
    } t_ds_rsp;

endpackage

### rtl/brms_div_sqrt.sv
// ----------------------------------------------------------------------------
// brms_div_sqrt: iterative mean and square root
// Restoring division of the square sum by the sample count, one quotient bit
// a cycle, then a digit-by-digit floor square root, one root bit a cycle.
// ----------------------------------------------------------------------------
module brms_div_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brms_pkg::t_ds_req i_req,
    output brms_pkg::t_ds_rsp o_rsp
);
    import brms_pkg::*;

    typedef enum logic [1:0] {
        D_IDLE,
        D_DIV,
        D_SQRT
    } t_dstate;

    t_dstate             r_state;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [CNT_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_div;
    logic [MEAN_W-1:0]   r_dvd;
    logic                r_zero;
    logic [2*SQRT_STEPS-1:0] r_rad;
    logic [LVL_W+1:0]    r_srem;
    logic [LVL_W-1:0]    r_root;

    logic [CNT_W:0]      div_trial;
    logic [CNT_W:0]      div_diff;
    logic                qbit;
    logic [LVL_W+3:0]    sq_cur;
    logic [LVL_W+3:0]    sq_trial;
    logic [LVL_W+3:0]    sq_diff;
    logic                rbit;

    // one division step: shift in the next dividend bit, try the subtract
    always_comb begin
        div_trial = {r_rem, r_dvd[MEAN_W-1]};
        div_diff  = div_trial - {1'b0, r_div};
        qbit      = (div_trial >= {1'b0, r_div});
    end

    // one root step: bring down two radicand bits, try root*4 + 1
    always_comb begin
        sq_cur   = {r_srem, r_rad[2*SQRT_STEPS-1 -: 2]};
        sq_trial = {2'b00, r_root, 2'b01};
        sq_diff  = sq_cur - sq_trial;
        rbit     = (sq_cur >= sq_trial);
    end

    // sequence division then root
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
        end else begin
            // flag the root once its last bit is in
            r_done <= (r_state == D_SQRT) && (r_step == STEP_W'(SQRT_STEPS - 1));
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        // high sum bits stay below the count, so start there
                        r_rem   <= {1'b0, i_req.sum[SUM_W-1 -: DIV_HI_W]};
                        r_dvd   <= i_req.sum[MEAN_W-1:0];
                        r_div   <= i_req.count;
                        r_zero  <= (i_req.count == '0);
                        r_step  <= '0;
                        r_state <= D_DIV;
                    end
                end
                D_DIV: begin
                    r_rem <= qbit ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
                    r_dvd <= {r_dvd[MEAN_W-2:0], qbit};
                    if (r_step == STEP_W'(MEAN_W - 1)) begin
                        // empty count gives a zero mean
                        r_rad   <= r_zero ? '0 : {1'b0, r_dvd[MEAN_W-2:0], qbit};
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_step  <= '0;
                        r_state <= D_SQRT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                D_SQRT: begin
                    r_srem <= rbit ? sq_diff[LVL_W+1:0] : sq_cur[LVL_W+1:0];
                    r_root <= {r_root[LVL_W-2:0], rbit};
                    r_rad  <= {r_rad[2*SQRT_STEPS-3:0], 2'b00};
                    if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                        r_state <= D_IDLE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

### rtl/block_rms_level_meter_unit.sv
// ----------------------------------------------------------------------------
// block_rms_level_meter_unit: per-channel block RMS meter with smoothing
// Accumulates squares per channel; at block end divides, takes the root and
// updates a one-pole smoothed level through one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------------
//  in       | sink      | i_in_valid / o_in_stall | kind, channel, sample, block_end
//  out      | source    | o_out_valid/i_out_stall | channel, rms, level, overlong
//  cfg      | APB slave | psel/penable/pready     | smoothing_alpha at address 0
//
//  A sample without block end is accepted, squared and accumulated.
//  A block-end sample also goes through the bit-serial divide and the
//  bit-serial root in brms_div_sqrt, plus the multiply steps.
//  o_in_stall is high from acceptance until the item is finished.
//  A finished result waits in the output register; a later block end holds
//  in its last step while that register is still full.
//  Reset clears all channel state and the smoothing weight at once.
// ----------------------------------------------------------------------------
module block_rms_level_meter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic [brms_pkg::CH_W-1:0]      i_channel,
    input  logic signed [brms_pkg::SMP_W-1:0] i_sample,
    input  logic                           i_block_end,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [brms_pkg::CH_W-1:0]      o_out_channel,
    output logic [brms_pkg::LVL_W-1:0]     o_instant_rms,
    output logic [brms_pkg::LVL_W-1:0]     o_smoothed_level,
    output logic                           o_overlong,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [brms_pkg::PADDR_W-1:0]   paddr,
    input  logic [brms_pkg::PDATA_W-1:0]   pwdata,
    output logic [brms_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import brms_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_START,
        S_ROOT,
        S_MIX1,
        S_MIX2,
        S_MIX3
    } t_state;

    t_state              r_state;
    logic [ALPHA_W-1:0]  r_alpha;
    logic [CH_W-1:0]     r_ch;
    logic [SMP_W-1:0]    r_mag;
    logic                r_end;
    logic [PROD_W-1:0]   r_prod;
    logic [MIX_W-1:0]    r_mix;
    logic [LVL_W-1:0]    r_rms;

    logic [SUM_W-1:0]    r_sum   [CHANNELS];
    logic [CNT_W-1:0]    r_count [CHANNELS];
    logic                r_mark  [CHANNELS];
    logic [LVL_W-1:0]    r_level [CHANNELS];

    logic                r_o_valid;
    logic [CH_W-1:0]     r_o_channel;
    logic [LVL_W-1:0]    r_o_rms;
    logic [LVL_W-1:0]    r_o_level;
    logic                r_o_overlong;

    logic                in_xfer;
    logic                cfg_write;
    logic [SMP_W-1:0]    in_mag;
    logic                ch_ok;
    logic [ALPHA_W-1:0]  alpha_sat;
    logic [ALPHA_W-1:0]  alpha_rest;
    logic [SMP_W-1:0]    mul_a;
    logic [SMP_W-1:0]    mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [MIX_W-1:0]    mix_sum;
    logic                out_free;
    logic                out_load;
    t_ds_req             ds_req;
    t_ds_rsp             ds_rsp;

    // input transfer, magnitude and channel range
    assign in_xfer = i_in_valid && !o_in_stall;
    assign in_mag  = i_sample[SMP_W-1] ? (SMP_W'(0) - SMP_W'(i_sample))
                                       : SMP_W'(i_sample);
    assign ch_ok   = ({1'b0, i_channel} < (CH_W + 1)'(CHANNELS));

    // saturate the weight to one and form its complement
    assign alpha_sat  = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign alpha_rest = ALPHA_ONE - alpha_sat;

    // shared multiplier: square, then the two smoothing products
    always_comb begin
        case (r_state)
            S_MIX1: begin
                mul_a = SMP_W'(alpha_rest);
                mul_b = r_rms;
            end
            S_MIX2: begin
                mul_a = SMP_W'(alpha_sat);
                mul_b = r_level[r_ch];
            end
            default: begin
                mul_a = r_mag;
                mul_b = r_mag;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign mix_sum  = r_mix + r_prod[MIX_W-1:0];
    assign out_free = !r_o_valid || !i_out_stall;
    assign out_load = (r_state == S_MIX3) && out_free;

    // divide/root request for the finishing channel
    assign ds_req.start = (r_state == S_START);
    assign ds_req.sum   = r_sum[r_ch];
    assign ds_req.count = r_count[r_ch];

    brms_div_sqrt u_div_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ds_req),
        .o_rsp   (ds_rsp)
    );

    // sequencer, channel state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c]   <= '0;
                r_count[c] <= '0;
                r_mark[c]  <= 1'b0;
                r_level[c] <= '0;
            end
        end else begin
            // load a finished result, or drop it once it is taken
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_kind) begin
                            for (int c = 0; c < CHANNELS; c++) begin
                                r_sum[c]   <= '0;
                                r_count[c] <= '0;
                                r_mark[c]  <= 1'b0;
                                r_level[c] <= '0;
                            end
                        end else if (ch_ok) begin
                            r_ch    <= i_channel;
                            r_mag   <= in_mag;
                            r_end   <= i_block_end;
                            r_state <= S_SQUARE;
                        end
                    end
                end
                S_SQUARE: begin
                    r_prod  <= mul_p;
                    r_state <= S_ACCUM;
                end
                S_ACCUM: begin
                    if (r_count[r_ch] < CNT_W'(MAX_BLOCK)) begin
                        r_sum[r_ch]   <= r_sum[r_ch] + SUM_W'(r_prod);
                        r_count[r_ch] <= r_count[r_ch] + 1'b1;
                    end else begin
                        r_mark[r_ch] <= 1'b1;
                    end
                    r_state <= r_end ? S_START : S_IDLE;
                end
                S_START: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (ds_rsp.done) begin
                        r_rms   <= ds_rsp.root;
                        r_state <= S_MIX1;
                    end
                end
                S_MIX1: begin
                    r_prod  <= mul_p;
                    r_state <= S_MIX2;
                end
                S_MIX2: begin
                    r_mix   <= r_prod[MIX_W-1:0];
                    r_prod  <= mul_p;
                    r_state <= S_MIX3;
                end
                S_MIX3: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_level[r_ch] <= mix_sum[MIX_W-1 -: LVL_W];
                        r_o_channel   <= r_ch;
                        r_o_rms       <= r_rms;
                        r_o_level     <= mix_sum[MIX_W-1 -: LVL_W];
                        r_o_overlong  <= r_mark[r_ch];
                        r_sum[r_ch]   <= '0;
                        r_count[r_ch] <= '0;
                        r_mark[r_ch]  <= 1'b0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // configuration register
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= '0;
        end else if (cfg_write && (paddr[PADDR_W-1] == 1'b0)) begin
            r_alpha <= pwdata[ALPHA_W-1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1] == 1'b0) ? PDATA_W'(r_alpha) : '0;
    assign pready = 1'b1;

    // ports
    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_o_valid;
    assign o_out_channel    = r_o_channel;
    assign o_instant_rms    = r_o_rms;
    assign o_smoothed_level = r_o_level;
    assign o_overlong       = r_o_overlong;

`ifndef SYNTHESIS
    // the root only completes while the sequencer waits for it
    a_done_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ds_rsp.done |-> (r_state == S_ROOT))
        else $error("root result outside wait step");

    // a root of a mean square of Q1.23 samples stays within full scale
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ds_rsp.done |-> (ds_rsp.root <= 24'h800000))
        else $error("root above full scale");

    // a new result only follows the smoothing step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_MIX3))
        else $error("result raised outside final step");

    // the sample count never passes the block limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START) |-> (r_count[r_ch] <= CNT_W'(MAX_BLOCK)))
        else $error("sample count above block limit");
`endif

endmodule

### tb/sv/brms_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brms_tb_pkg: shared codes of the block RMS level meter testbench
// Item kinds and configuration register addresses used by both the
// stimulus and the checker.
// ----------------------------------------------------------------------------
package brms_tb_pkg;

    // what one input transfer carries
    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_CLEAR  = 1'b1
    } t_item_kind;

    // register i sits at byte address 4*i; the spare address is past the list
    localparam logic [brms_pkg::PADDR_W-1:0] REG_ALPHA_ADDR = 3'd0;
    localparam logic [brms_pkg::PADDR_W-1:0] REG_SPARE_ADDR = 3'd4;

endpackage

### tb/sv/block_rms_level_meter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_rms_level_meter_checker: scoreboard for the block RMS level meter
// Watches the input, output and configuration ports, keeps its own copy of
// the per-channel accumulators and smoothed levels, and compares every
// output transfer field by field against the oldest predicted block report.
// ----------------------------------------------------------------------------
module block_rms_level_meter_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              kind,
    input  logic [brms_pkg::CH_W-1:0]         channel,
    input  logic signed [brms_pkg::SMP_W-1:0] sample,
    input  logic                              block_end,
    // output channel
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [brms_pkg::CH_W-1:0]         out_channel,
    input  logic [brms_pkg::LVL_W-1:0]        instant_rms,
    input  logic [brms_pkg::LVL_W-1:0]        smoothed_level,
    input  logic                              overlong,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [brms_pkg::PADDR_W-1:0]      paddr,
    input  logic [brms_pkg::PDATA_W-1:0]      pwdata,
    input  logic [brms_pkg::PDATA_W-1:0]      prdata,
    // status towards the stimulus
    output int                                error_count,
    output int                                pending_results
);
    import brms_pkg::*;
    import brms_tb_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0]  chan;
        logic [LVL_W-1:0] rms;
        logic [LVL_W-1:0] lvl;
        logic             over;
    } t_block_report;

    t_block_report       due_reports[$];

    logic [SUM_W-1:0]    acc_sum     [CHANNELS];
    logic [CNT_W-1:0]    acc_count   [CHANNELS];
    logic                acc_dropped [CHANNELS];
    logic [LVL_W-1:0]    ch_level    [CHANNELS];
    logic [ALPHA_W-1:0]  alpha_reg;

    initial error_count = 0;

    // print one line and count it
    task automatic report_mismatch(string what, longint unsigned got,
                                   longint unsigned want);
        $display("%0t ns checker: %s mismatch, got %0d, want %0d",
                 $time, what, got, want);
        error_count++;
    endtask

    // floor square root by trial of each root bit from the top
    function automatic logic [LVL_W-1:0] floor_root(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        int          b;
        root = '0;
        for (b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root[LVL_W-1:0];
    endfunction

    // zero every channel's accumulator and level
    task automatic clear_meter();
        int c;
        for (c = 0; c < CHANNELS; c++) begin
            acc_sum[c]     = '0;
            acc_count[c]   = '0;
            acc_dropped[c] = 1'b0;
            ch_level[c]    = '0;
        end
    endtask

    // accumulate one accepted item and predict the block report it closes
    task automatic meter_take_sample();
        logic [24:0]        mag;
        logic [63:0]        mean;
        logic [63:0]        mix;
        logic [LVL_W-1:0]   rms;
        logic [ALPHA_W-1:0] a;
        t_block_report      rep;
        if (kind == KIND_CLEAR) begin
            clear_meter();
        end else begin
            mag = sample[SMP_W-1] ? 25'h1000000 - {1'b0, sample} : {1'b0, sample};
            if (acc_count[channel] < MAX_BLOCK) begin
                acc_sum[channel]   = acc_sum[channel] + mag * mag;
                acc_count[channel] = acc_count[channel] + 1'b1;
            end else begin
                acc_dropped[channel] = 1'b1;
            end
            if (block_end) begin
                mean = (acc_count[channel] != 0)
                     ? 64'(acc_sum[channel]) / 64'(acc_count[channel]) : 64'd0;
                rms  = floor_root(mean);
                a    = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
                mix  = 64'(ALPHA_ONE - a) * 64'(rms) + 64'(a) * 64'(ch_level[channel]);
                ch_level[channel] = mix[39:16];
                rep.chan = channel;
                rep.rms  = rms;
                rep.lvl  = ch_level[channel];
                rep.over = acc_dropped[channel];
                due_reports.push_back(rep);
                acc_sum[channel]     = '0;
                acc_count[channel]   = '0;
                acc_dropped[channel] = 1'b0;
            end
        end
    endtask

    // compare one output transfer with the oldest prediction
    task automatic check_report();
        t_block_report want;
        if (due_reports.size() == 0) begin
            report_mismatch("unexpected result on channel", out_channel, 0);
        end else begin
            want = due_reports.pop_front();
            if (out_channel !== want.chan)
                report_mismatch("out_channel", out_channel, want.chan);
            if (instant_rms !== want.rms)
                report_mismatch("instant_rms", instant_rms, want.rms);
            if (smoothed_level !== want.lvl)
                report_mismatch("smoothed_level", smoothed_level, want.lvl);
            if (overlong !== want.over)
                report_mismatch("overlong", overlong, want.over);
        end
    endtask

    // follow the block at every rising edge
    always @(posedge clk) begin
        if (!rst_n) begin
            clear_meter();
            alpha_reg = '0;
            due_reports.delete();
        end else begin
            // track register writes and check read-back
            if (psel && penable && pready && paddr == REG_ALPHA_ADDR) begin
                if (pwrite) begin
                    alpha_reg = pwdata[ALPHA_W-1:0];
                end else if (prdata !== PDATA_W'(alpha_reg)) begin
                    report_mismatch("smoothing_alpha read-back", prdata, alpha_reg);
                end
            end
            if (out_valid && !out_stall)
                check_report();
            if (in_valid && !in_stall)
                meter_take_sample();
        end
        pending_results <= due_reports.size();
    end

endmodule

### tb/sv/block_rms_level_meter_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_rms_level_meter_unit_test: top of the block RMS level meter testbench
// Drives directed and random sample streams through the meter under several
// smoothing weights, with random idling on both sides, a long output hold-off
// and two blocks that reach and pass the block length limit. A checker beside
// the block predicts and compares each block report; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module block_rms_level_meter_unit_test;

    import brms_pkg::*;
    import brms_tb_pkg::*;

    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = 120;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 200;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_kind;
    logic [CH_W-1:0]         i_channel;
    logic signed [SMP_W-1:0] i_sample;
    logic                    i_block_end;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [CH_W-1:0]         o_out_channel;
    logic [LVL_W-1:0]        o_instant_rms;
    logic [LVL_W-1:0]        o_smoothed_level;
    logic                    o_overlong;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [PDATA_W-1:0]      pwdata;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;

    int                      error_count;
    int                      pending_results;

    // idling controls shared between the stimulus and the stall process
    bit                      in_quiet     = 1'b0;
    bit                      out_quiet    = 1'b0;
    bit                      hold_request = 1'b0;

    always #5 i_clk = ~i_clk;

    block_rms_level_meter_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_channel        (i_channel),
        .i_sample         (i_sample),
        .i_block_end      (i_block_end),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_channel    (o_out_channel),
        .o_instant_rms    (o_instant_rms),
        .o_smoothed_level (o_smoothed_level),
        .o_overlong       (o_overlong),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    block_rms_level_meter_checker meter_checker (
        .clk             (i_clk),
        .rst_n           (i_rst_n),
        .in_valid        (i_in_valid),
        .in_stall        (o_in_stall),
        .kind            (i_kind),
        .channel         (i_channel),
        .sample          (i_sample),
        .block_end       (i_block_end),
        .out_valid       (o_out_valid),
        .out_stall       (i_out_stall),
        .out_channel     (o_out_channel),
        .instant_rms     (o_instant_rms),
        .smoothed_level  (o_smoothed_level),
        .overlong        (o_overlong),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    // end the run if it hangs
    initial begin
        #(20_000_000);
        $display("block_rms_level_meter_unit_test: errors");
        $finish;
    end

    // receiver stalls: short runs mostly, a few long ones, and a long hold on request
    initial begin : out_stall_gen
        int unsigned pick;
        int unsigned run;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall  <= 1'b0;
                hold_request = 1'b0;
            end else if (out_quiet) begin
                i_out_stall <= 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    i_out_stall <= 1'b0;
                    run = $urandom_range(1, 12);
                end else if (pick < 93) begin
                    i_out_stall <= 1'b1;
                    run = $urandom_range(1, 4);
                end else begin
                    i_out_stall <= 1'b1;
                    run = $urandom_range(20, 80);
                end
                repeat (run - 1) @(negedge i_clk);
            end
        end
    end

    // idle for a random gap, then offer one item and hold it until the transfer
    task automatic send_item(t_item_kind k, logic [CH_W-1:0] ch,
                             logic [SMP_W-1:0] smp, logic be);
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(0, 99);
        if (in_quiet || pick < 60)
            gap = 0;
        else if (pick < 93)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(15, 60);
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_kind      <= k;
        i_channel   <= ch;
        i_sample    <= smp;
        i_block_end <= be;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drop valid, wait for every expected report, then let the block go idle
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one configuration access: setup cycle, then access until pready
    task automatic apb_access(logic wr, logic [PADDR_W-1:0] addr,
                              logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // sample values weighted towards the extremes and small magnitudes
    function automatic logic [SMP_W-1:0] pick_sample();
        int unsigned      pick;
        logic [SMP_W-1:0] v;
        pick = $urandom_range(0, 99);
        v    = SMP_W'($urandom);
        if (pick < 4)
            v = 24'h7FFFFF;
        else if (pick < 8)
            v = 24'h800000;
        else if (pick < 11)
            v = '0;
        else if (pick < 14)
            v = 24'hFFFFFF;
        else if (pick < 34)
            v = {{15{v[23]}}, v[8:0]};
        return v;
    endfunction

    // random traffic: mostly whole blocks on one channel, some loose items and clears
    task automatic run_random(int unsigned n_items);
        int unsigned     sent;
        int unsigned     pick;
        int unsigned     len;
        int unsigned     j;
        logic [CH_W-1:0] ch;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            ch   = CH_W'($urandom_range(0, CHANNELS - 1));
            if (pick < 3) begin
                send_item(KIND_CLEAR, ch, pick_sample(), $urandom_range(0, 1) == 1);
                sent++;
            end else if (pick < 75) begin
                len = $urandom_range(1, 10);
                for (j = 0; j < len; j++)
                    send_item(KIND_SAMPLE, ch, pick_sample(), j == len - 1);
                sent += len;
            end else begin
                send_item(KIND_SAMPLE, ch, pick_sample(), $urandom_range(0, 3) == 0);
                sent++;
            end
        end
    endtask

    // stimulus
    initial begin : stimulus
        int                 phase;
        int                 j;
        logic [ALPHA_W-1:0] next_alpha;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_kind      = KIND_SAMPLE;
        i_channel   = '0;
        i_sample    = '0;
        i_block_end = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset weight reads back as zero; single-sample blocks at the extremes
        apb_access(1'b0, REG_ALPHA_ADDR, '0);
        send_item(KIND_SAMPLE, 3'd0, 24'h7FFFFF, 1'b1);
        send_item(KIND_SAMPLE, 3'd1, 24'h800000, 1'b1);
        send_item(KIND_SAMPLE, 3'd2, 24'h000000, 1'b1);
        send_item(KIND_SAMPLE, 3'd3, 24'hFFFFFF, 1'b1);
        // interleaved two-sample blocks, then two single-sample blocks
        send_item(KIND_SAMPLE, 3'd4, 24'd1000, 1'b0);
        send_item(KIND_SAMPLE, 3'd5, 24'hFFFFFB, 1'b0);
        send_item(KIND_SAMPLE, 3'd4, 24'd3000, 1'b1);
        send_item(KIND_SAMPLE, 3'd5, 24'd7, 1'b1);
        send_item(KIND_SAMPLE, 3'd6, 24'h555555, 1'b1);
        send_item(KIND_SAMPLE, 3'd7, 24'hAAAAAA, 1'b1);

        // weight of one holds the old level; a clear drops it
        settle();
        apb_access(1'b1, REG_ALPHA_ADDR, PDATA_W'(ALPHA_ONE));
        apb_access(1'b0, REG_ALPHA_ADDR, '0);
        send_item(KIND_SAMPLE, 3'd0, 24'h000000, 1'b1);
        send_item(KIND_CLEAR, 3'd7, 24'h7FFFFF, 1'b1);
        send_item(KIND_SAMPLE, 3'd0, 24'h400000, 1'b1);

        // write past the register list is ignored; weight above one saturates
        settle();
        apb_access(1'b1, REG_SPARE_ADDR, 32'h0000_1234);
        apb_access(1'b1, REG_ALPHA_ADDR, 32'h0001_FFFF);
        apb_access(1'b0, REG_ALPHA_ADDR, '0);
        send_item(KIND_SAMPLE, 3'd1, 24'h7FFFFF, 1'b1);

        // half weight: level climbs towards full scale
        settle();
        apb_access(1'b1, REG_ALPHA_ADDR, 32'h0000_8000);
        apb_access(1'b0, REG_ALPHA_ADDR, '0);
        send_item(KIND_SAMPLE, 3'd1, 24'h800000, 1'b1);
        send_item(KIND_SAMPLE, 3'd1, 24'h800000, 1'b1);

        // block of exactly the limit at full scale, then one past it with drops
        settle();
        in_quiet  = 1'b1;
        out_quiet = 1'b1;
        for (j = 0; j < MAX_BLOCK; j++)
            send_item(KIND_SAMPLE, 3'd5, 24'h800000, j == MAX_BLOCK - 1);
        for (j = 0; j < MAX_BLOCK + 2; j++)
            send_item(KIND_SAMPLE, 3'd2, pick_sample(), j == MAX_BLOCK + 1);
        in_quiet  = 1'b0;
        out_quiet = 1'b0;

        // random phases under different weights
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0:       next_alpha = 17'd1;
                1:       next_alpha = 17'd65535;
                3:       next_alpha = '0;
                4:       next_alpha = ALPHA_ONE;
                default: next_alpha = ALPHA_W'($urandom_range(0, 131071));
            endcase
            apb_access(1'b1, REG_ALPHA_ADDR, PDATA_W'(next_alpha));
            apb_access(1'b0, REG_ALPHA_ADDR, '0);
            // one phase runs flat out on both sides
            in_quiet  = (phase == 2);
            out_quiet = (phase == 2);
            // hold off the receiver long enough to back the block up
            if (phase == 0)
                hold_request = 1'b1;
            run_random(PHASE_ITEMS);
        end
        in_quiet  = 1'b0;
        out_quiet = 1'b0;

        settle();
        if (error_count == 0) begin
            $display("block_rms_level_meter_unit_test: clean");
        end else begin
            $display("block_rms_level_meter_unit_test: errors");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/brms_pkg.sv
rtl/brms_div_sqrt.sv
rtl/block_rms_level_meter_unit.sv
tb/sv/brms_tb_pkg.sv
tb/sv/block_rms_level_meter_checker.sv
tb/sv/block_rms_level_meter_unit_test.sv
